FILE: src/tpa_pkg.sv
// ----------------------------------------------------------------------------
// tpa_pkg
// Shared widths, register indexes, reset values and result layout for the
// tachometer period averager.
// ----------------------------------------------------------------------------
package tpa_pkg;

  localparam int TIME_W      = 32;
  localparam int INTERVAL_W  = 24;
  localparam int MINP_W      = 8;
  localparam int PPR_W       = 5;
  localparam int COUNT_W     = 16;
  localparam int MEAN_W      = 38;
  localparam int RPM_W       = 31;
  localparam int IN_DATA_W   = 32;
  localparam int IN_USER_W   = 1;
  localparam int OUT_DATA_W  = 88;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 24;

  localparam int COUNT_LSB   = 0;
  localparam int MEAN_LSB    = COUNT_LSB + COUNT_W;
  localparam int RPM_LSB     = MEAN_LSB + MEAN_W;
  localparam int PAD_LSB     = RPM_LSB + RPM_W;

  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;
  typedef logic [IN_USER_W-1:0]  mode_t;

  localparam cfg_addr_t CFG_UPDATE_INTERVAL = 2'd0;
  localparam cfg_addr_t CFG_MIN_PULSES      = 2'd1;
  localparam cfg_addr_t CFG_PULSES_PER_REV  = 2'd2;

  localparam mode_t MODE_PULSE = 1'b0;
  localparam mode_t MODE_CHECK = 1'b1;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 24'd200000;
  localparam logic [MINP_W-1:0]     MINP_RST     = 8'd4;
  localparam logic [PPR_W-1:0]      PPR_RST      = 5'd2;

  localparam longint unsigned RPM_SCALE = 64'd60000000;
  localparam logic [RPM_W-1:0]  RPM_MAX  = {RPM_W{1'b1}};
  localparam logic [MEAN_W-1:0] MEAN_MAX = {MEAN_W{1'b1}};

endpackage

FILE: src/tpa_ring_mem.sv
// ----------------------------------------------------------------------------
// tpa_ring_mem
// Interval ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tpa_ring_mem #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = 6,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata_r
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

FILE: src/tpa_div.sv
// ----------------------------------------------------------------------------
// tpa_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tpa_div #(
  parameter int NUM_W = 36,
  parameter int DEN_W = 47
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quot,
  output logic             done
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r;
  logic [NUM_W-1:0] q_r, q_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   cand;
  logic             fits;

  assign cand = {rem_r, q_r[NUM_W-1]};
  assign fits = cand >= {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      q_nxt   = num;
      cnt_nxt = CNT_W'(NUM_W);
    end else if (cnt_r != '0) begin
      rem_nxt  = fits ? DEN_W'(cand - {1'b0, den_r}) : cand[DEN_W-1:0];
      q_nxt    = {q_r[NUM_W-2:0], fits};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign quot = q_r;
  assign done = done_r;

endmodule

FILE: src/tachometer_period_average.sv
// ----------------------------------------------------------------------------
// tachometer_period_average
// Pulse-period moving average over a ring of DEPTH intervals, with RPM reports.
//
// Input channel (in_*): in_tuser is the item kind (pulse edge or report
// check), in_tdata the free-running microsecond timestamp. One item is taken
// at a time. For a pulse, the ring slot is read in the accept cycle and the
// updated interval is written back the next, which also updates the running
// sum. A due check runs through the bit-serial divider that forms
// rpm = 60e6*DEPTH / (pulses_per_rev * sum).
// Result channel (out_*): one item per due check, held in an output
// register; new items are taken while it waits. A report that finishes while
// the previous one is still not taken holds until out_tready frees the
// register. Reset clears all control state and sets configuration to its
// reset values; unwritten ring slots read as zero via a fill flag, so no
// clearing pass runs. The user must write configuration (cfg_*) only while
// the block is idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module tachometer_period_average #(
  parameter int DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [tpa_pkg::IN_DATA_W-1:0] in_tdata,   // [31:0] time_us
  input  logic [tpa_pkg::IN_USER_W-1:0] in_tuser,   // [0] mode
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [15:0] pulse_count, [53:16] mean_period_q6, [84:54] rpm, [87:85] zero
  output logic [tpa_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_we,
  input  logic [tpa_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [tpa_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  import tpa_pkg::*;

  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SUM_W  = TIME_W + IDX_W;
  localparam int DEN_W  = PPR_W + SUM_W;
  localparam longint unsigned NUM_VAL = RPM_SCALE * DEPTH;
  localparam int NUM_W  = $clog2(NUM_VAL + 1);
  localparam int SW_W   = (SUM_W > MEAN_W) ? SUM_W : MEAN_W;
  localparam int QW_W   = (NUM_W > RPM_W) ? NUM_W : RPM_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PULSE = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_START = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  logic [2:0]            state_r, state_nxt;
  logic [IDX_W-1:0]      widx_r, widx_nxt;
  logic                  full_r, full_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [TIME_W-1:0]     last_pulse_r, last_pulse_nxt;
  logic [TIME_W-1:0]     last_report_r, last_report_nxt;
  logic [COUNT_W-1:0]    pulses_r, pulses_nxt;
  logic [INTERVAL_W-1:0] interval_r;
  logic [MINP_W-1:0]     minp_r;
  logic [PPR_W-1:0]      ppr_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [TIME_W-1:0]     delta_r;
  logic [COUNT_W-1:0]    count_cap_r;
  logic [SUM_W-1:0]      sum_cap_r;
  logic                  rpm_zero_r;
  logic [DEN_W-1:0]      den_r;

  logic                  accept;
  logic                  is_check;
  logic                  due;
  logic [TIME_W-1:0]     rd_data;
  logic [TIME_W-1:0]     old_interval;
  logic [IDX_W:0]        widx_inc;
  logic                  mem_we;
  logic                  div_start;
  logic                  div_done;
  logic [NUM_W-1:0]      quot;
  logic [SW_W-1:0]       sum_wide;
  logic [MEAN_W-1:0]     mean_sat;
  logic [QW_W-1:0]       quot_wide;
  logic [RPM_W-1:0]      rpm_val;
  logic                  load_out;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign is_check  = (in_tuser == MODE_CHECK);
  assign due       = (in_tdata - last_report_r) >= TIME_W'(interval_r);

  assign old_interval = full_r ? rd_data : '0;
  assign widx_inc     = {1'b0, widx_r} + 1'b1;
  assign mem_we       = (state_r == ST_PULSE);
  assign div_start    = (state_r == ST_START);

  assign sum_wide  = SW_W'(sum_cap_r);
  assign mean_sat  = (sum_wide > SW_W'(MEAN_MAX)) ? MEAN_MAX : sum_wide[MEAN_W-1:0];
  assign quot_wide = QW_W'(quot);
  assign rpm_val   = rpm_zero_r ? '0 :
                     (quot_wide > QW_W'(RPM_MAX)) ? RPM_MAX : quot_wide[RPM_W-1:0];
  assign load_out  = (state_r == ST_DONE) && (!out_valid_r || out_tready);

  tpa_ring_mem #(
    .DEPTH  (DEPTH),
    .ADDR_W (IDX_W),
    .DATA_W (TIME_W)
  ) u_ring (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (widx_r),
    .wdata   (delta_r),
    .raddr   (widx_r),
    .rdata_r (rd_data)
  );

  tpa_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (NUM_W'(NUM_VAL)),
    .den   (den_r),
    .quot  (quot),
    .done  (div_done)
  );

  always_comb begin
    state_nxt       = state_r;
    widx_nxt        = widx_r;
    full_nxt        = full_r;
    sum_nxt         = sum_r;
    last_pulse_nxt  = last_pulse_r;
    last_report_nxt = last_report_r;
    pulses_nxt      = pulses_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (!is_check) begin
            last_pulse_nxt = in_tdata;
            pulses_nxt     = pulses_r + 1'b1;
            state_nxt      = ST_PULSE;
          end else if (due) begin
            pulses_nxt      = '0;
            last_report_nxt = in_tdata;
            state_nxt       = ST_MUL;
          end
        end
      end
      ST_PULSE: begin
        sum_nxt = sum_r - SUM_W'(old_interval) + SUM_W'(delta_r);
        if (widx_inc >= (IDX_W+1)'(DEPTH)) begin
          widx_nxt = '0;
          full_nxt = 1'b1;
        end else begin
          widx_nxt = widx_inc[IDX_W-1:0];
        end
        state_nxt = ST_IDLE;
      end
      ST_MUL: begin
        state_nxt = ST_START;
      end
      ST_START: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      widx_r        <= '0;
      full_r        <= 1'b0;
      sum_r         <= '0;
      last_pulse_r  <= '0;
      last_report_r <= '0;
      pulses_r      <= '0;
      out_valid_r   <= 1'b0;
      interval_r    <= INTERVAL_RST;
      minp_r        <= MINP_RST;
      ppr_r         <= PPR_RST;
    end else begin
      state_r       <= state_nxt;
      widx_r        <= widx_nxt;
      full_r        <= full_nxt;
      sum_r         <= sum_nxt;
      last_pulse_r  <= last_pulse_nxt;
      last_report_r <= last_report_nxt;
      pulses_r      <= pulses_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          CFG_UPDATE_INTERVAL: interval_r <= cfg_wdata;
          CFG_MIN_PULSES:      minp_r     <= cfg_wdata[MINP_W-1:0];
          CFG_PULSES_PER_REV:  ppr_r      <= cfg_wdata[PPR_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !is_check) begin
      delta_r <= in_tdata - last_pulse_r;
    end
    if (accept && is_check) begin
      count_cap_r <= pulses_r;
      sum_cap_r   <= sum_r;
      rpm_zero_r  <= (pulses_r < COUNT_W'(minp_r)) || (sum_r == '0) || (ppr_r == '0);
    end
    if (state_r == ST_MUL) begin
      den_r <= DEN_W'(ppr_r) * DEN_W'(sum_cap_r);
    end
    if (load_out) begin
      out_data_r <= {{(OUT_DATA_W - PAD_LSB){1'b0}}, rpm_val, mean_sat, count_cap_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

FILE: src/tpa_checker.sv
// ----------------------------------------------------------------------------
// tpa_checker
// Port-level checks for the tachometer period averager, bound to the top.
// ----------------------------------------------------------------------------
module tpa_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic [tpa_pkg::IN_USER_W-1:0]  in_tuser,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [tpa_pkg::OUT_DATA_W-1:0] out_tdata
);

  import tpa_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result item changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_pulse_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == MODE_PULSE) && !out_tvalid |=> !out_tvalid)
    else $error("pulse item produced a result");

  a_busy_before_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result appeared without a report computation");

  a_rpm_needs_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[PAD_LSB-1:RPM_LSB] != '0) |->
      (out_tdata[RPM_LSB-1:MEAN_LSB] != '0))
    else $error("nonzero rpm with zero period sum");

endmodule

bind tachometer_period_average tpa_checker u_tpa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: sim/tb_tachometer_period_average.sv
// ----------------------------------------------------------------------------
// tb_tachometer_period_average
// Self-checking bench for the tachometer period averager. A queue of pulse
// and report-check items feeds a bursty driver, while the receiver stalls on
// its own changing pattern. Each accepted item runs through a behavioral
// model of the interval ring, the running sum and the report timer. Every
// report taken from the block is compared against the oldest predicted one.
// A directed opening covers zero sums, saturated speed, zero pulses per
// revolution, timer wrap and early checks. Randomized runs then follow at
// several register settings, and a closing pulse train is reported at the
// widest pulses-per-revolution setting.
// ----------------------------------------------------------------------------
module tb_tachometer_period_average;
  import tpa_pkg::*;

  localparam int RING_DEPTH     = 64;
  localparam int IDLE_GAP       = 64;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam cfg_addr_t CFG_SPARE = 2'd3;

  typedef struct packed {
    mode_t             kind;
    logic [TIME_W-1:0] stamp;
  } tach_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [MEAN_W-1:0]  mean;
    logic [RPM_W-1:0]   rpm;
  } tach_report_t;

  typedef enum logic [1:0] {RX_FREE, RX_CHOPPY, RX_STARVED} rx_style_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;   // [31:0] time_us
  logic [IN_USER_W-1:0]  in_tuser;   // [0] mode
  logic                  out_tvalid;
  logic                  out_tready;
  // [15:0] pulse_count, [53:16] mean_period_q6, [84:54] rpm, [87:85] zero
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tach_item_t   stim_q[$];
  tach_item_t   next_item;
  int           burst_left;
  int           gap_left;
  rx_style_t    rx_style;
  int           rx_hold;
  int           idle_cycles;
  int           mismatches;
  logic [TIME_W-1:0] stim_time;

  logic [TIME_W-1:0]             ring_mem [RING_DEPTH];
  logic [$clog2(RING_DEPTH)-1:0] ring_wr;
  logic [63:0]                   period_sum;
  logic [TIME_W-1:0]             last_pulse_us;
  logic [TIME_W-1:0]             last_report_us;
  logic [COUNT_W-1:0]            pulse_tally;
  logic [INTERVAL_W-1:0]         exp_interval;
  logic [MINP_W-1:0]             exp_minp;
  logic [PPR_W-1:0]              exp_ppr;
  tach_report_t                  pending_reports[$];

  tachometer_period_average DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic step_tach_model(input mode_t kind, input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] delta;
    logic [TIME_W-1:0] elapsed;
    logic [63:0]       den;
    logic [63:0]       quot;
    tach_report_t      rep;
    if (kind == MODE_PULSE) begin
      delta = now - last_pulse_us;
      period_sum = period_sum - ring_mem[ring_wr] + delta;
      ring_mem[ring_wr] = delta;
      ring_wr = ring_wr + 1'b1;
      last_pulse_us = now;
      pulse_tally = pulse_tally + 1'b1;
    end else begin
      elapsed = now - last_report_us;
      if (elapsed >= exp_interval) begin
        rep.count = pulse_tally;
        rep.mean = (period_sum > MEAN_MAX) ? MEAN_MAX : period_sum[MEAN_W-1:0];
        if (pulse_tally < exp_minp || period_sum == 0 || exp_ppr == 0) begin
          rep.rpm = '0;
        end else begin
          den = exp_ppr * period_sum;
          quot = (RPM_SCALE * RING_DEPTH) / den;
          rep.rpm = (quot > RPM_MAX) ? RPM_MAX : quot[RPM_W-1:0];
        end
        pending_reports.push_back(rep);
        pulse_tally = '0;
        last_report_us = now;
      end
    end
  endtask

  task automatic check_report(input logic [OUT_DATA_W-1:0] word);
    tach_report_t got;
    tach_report_t want;
    got.count = word[COUNT_LSB +: COUNT_W];
    got.mean  = word[MEAN_LSB +: MEAN_W];
    got.rpm   = word[RPM_LSB +: RPM_W];
    if (pending_reports.size() == 0) begin
      if (mismatches < 10)
        $display("unexpected report at %0t: count %0d mean %0d rpm %0d",
                 $time, got.count, got.mean, got.rpm);
      mismatches++;
    end else begin
      want = pending_reports.pop_front();
      if (got.count !== want.count || got.mean !== want.mean || got.rpm !== want.rpm) begin
        if (mismatches < 10)
          $display("report mismatch at %0t: count exp %0d got %0d, mean exp %0d got %0d, %s",
                   $time, want.count, got.count, want.mean, got.mean,
                   $sformatf("rpm exp %0d got %0d", want.rpm, got.rpm));
        mismatches++;
      end
    end
  endtask

  task automatic push_item(input mode_t kind, input logic [TIME_W-1:0] stamp);
    stim_q.push_back(tach_item_t'{kind: kind, stamp: stamp});
  endtask

  // mostly well-ordered timestamps, with some items at arbitrary times
  task automatic push_run(input int n, input int step_max, input int check_odds);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        push_item(mode_t'($urandom_range(0, 1)), $urandom());
      end else begin
        stim_time += $urandom_range(0, step_max);
        push_item(($urandom_range(1, check_odds) == 1) ? MODE_CHECK : MODE_PULSE, stim_time);
      end
    end
  endtask

  task automatic write_reg(input cfg_addr_t addr, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // hold until every item is taken and every report is back, then let the block settle
  task automatic wait_quiet;
    do begin
      @(posedge clk);
      #1;
    end while (stim_q.size() != 0 || in_tvalid || pending_reports.size() != 0);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left != 0) begin
        in_tvalid <= 1'b0;
        gap_left  <= gap_left - 1;
      end else if (stim_q.size() != 0) begin
        next_item = stim_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= next_item.stamp;
        in_tuser  <= next_item.kind;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_style   <= RX_FREE;
      rx_hold    <= 0;
    end else begin
      if (rx_hold == 0) begin
        rx_style <= rx_style_t'($urandom_range(0, 2));
        rx_hold  <= $urandom_range(50, 400);
      end else begin
        rx_hold <= rx_hold - 1;
      end
      case (rx_style)
        RX_FREE:    out_tready <= 1'b1;
        RX_CHOPPY:  out_tready <= ($urandom_range(0, 3) != 0);
        default:    out_tready <= ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_UPDATE_INTERVAL: exp_interval = cfg_wdata[INTERVAL_W-1:0];
          CFG_MIN_PULSES:      exp_minp     = cfg_wdata[MINP_W-1:0];
          CFG_PULSES_PER_REV:  exp_ppr      = cfg_wdata[PPR_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) step_tach_model(in_tuser, in_tdata);
      if (out_tvalid && out_tready) check_report(out_tdata);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int step_max;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = MODE_PULSE;
    out_tready = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = '0;
    cfg_wdata  = '0;
    idle_cycles = 0;
    mismatches  = 0;
    stim_time   = '0;
    for (int i = 0; i < RING_DEPTH; i++) ring_mem[i] = '0;
    ring_wr        = '0;
    period_sum     = '0;
    last_pulse_us  = '0;
    last_report_us = '0;
    pulse_tally    = '0;
    exp_interval   = INTERVAL_RST;
    exp_minp       = MINP_RST;
    exp_ppr        = PPR_RST;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // report at the reset settings, too few pulses
    push_item(MODE_CHECK, 32'd200000);
    wait_quiet();

    write_reg(CFG_UPDATE_INTERVAL, 24'd0);
    write_reg(CFG_MIN_PULSES, 24'd0);
    write_reg(CFG_PULSES_PER_REV, 24'd1);
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom()));
    push_item(MODE_CHECK, 32'd0);
    push_item(MODE_PULSE, 32'd0);
    push_item(MODE_PULSE, 32'd0);
    push_item(MODE_CHECK, 32'd0);
    push_item(MODE_PULSE, 32'd1);
    push_item(MODE_CHECK, 32'd1);
    push_item(MODE_PULSE, 32'hFFFF_FFFF);
    push_item(MODE_PULSE, 32'h0000_0010);
    push_item(MODE_CHECK, 32'hFFFF_FFFF);
    push_item(MODE_CHECK, 32'd3);
    wait_quiet();

    // longest interval, early checks on both sides of the timer wrap
    write_reg(CFG_UPDATE_INTERVAL, 24'hFF_FFFF);
    write_reg(CFG_PULSES_PER_REV, 24'd0);
    push_item(MODE_PULSE, 32'd100);
    push_item(MODE_PULSE, 32'd300);
    push_item(MODE_CHECK, 32'd3 + 32'h00FF_FFFE);
    push_item(MODE_CHECK, 32'd3 + 32'h00FF_FFFF);
    push_item(MODE_CHECK, 32'hFFFF_FFFF);
    push_item(MODE_CHECK, 32'h00FF_FFF0);
    push_item(MODE_CHECK, 32'h00FF_FFFE);
    wait_quiet();

    write_reg(CFG_UPDATE_INTERVAL, 24'd1000);
    write_reg(CFG_MIN_PULSES, 24'd255);
    write_reg(CFG_PULSES_PER_REV, 24'd16);
    stim_time = 32'h0100_0000;
    push_run(400, 6, 20);
    wait_quiet();

    stim_time = 32'hFFFF_0000;
    repeat (4) begin
      write_reg(CFG_UPDATE_INTERVAL, CFG_DATA_W'($urandom_range(1000, 20000)));
      write_reg(CFG_MIN_PULSES, CFG_DATA_W'($urandom_range(0, 8)));
      write_reg(CFG_PULSES_PER_REV, CFG_DATA_W'($urandom_range(1, 16)));
      case ($urandom_range(0, 2))
        0:       step_max = 60;
        1:       step_max = 2500;
        default: step_max = 200000;
      endcase
      push_run(250, step_max, 4);
      wait_quiet();
    end

    // pulse train, one report at the widest pulses-per-revolution setting
    write_reg(CFG_UPDATE_INTERVAL, 24'd0);
    write_reg(CFG_MIN_PULSES, 24'd0);
    write_reg(CFG_PULSES_PER_REV, 24'd31);
    repeat (180) begin
      stim_time += $urandom_range(1, 100);
      push_item(MODE_PULSE, stim_time);
    end
    push_item(MODE_CHECK, stim_time);
    wait_quiet();

    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
